### src/acr_pkg.sv
// shared types and constants of the box overlap and push-out block
// no dependencies; used by acr_corner and aabb_collision_resolve_core
package acr_pkg;

    localparam int COORD_BITS_DEF = 16;
    localparam int SIZE_BITS      = 12;
    // distance from an inside corner to an edge is within +/- (2^SIZE_BITS - 1)
    localparam int DIST_BITS      = SIZE_BITS + 1;
    localparam int CFG_IDX_W      = 4;
    localparam int CFG_DATA_W     = SIZE_BITS;

    localparam logic [CFG_IDX_W-1:0] CFG_SELF_WIDTH   = 4'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SELF_HEIGHT  = 4'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TRIGGER_MODE = 4'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_MOVABLE      = 4'd3;

    typedef enum logic [1:0] {
        EV_NONE    = 2'd0,
        EV_TRIGGER = 2'd1,
        EV_SOLID   = 2'd2
    } t_event;

    // push-out candidate of one corner
    typedef struct packed {
        logic                        hit;
        logic                        on_x;
        logic signed [DIST_BITS-1:0] depth;
        logic [SIZE_BITS-1:0]        mag;
    } t_push;

    function automatic logic [SIZE_BITS-1:0] dist_mag(input logic signed [DIST_BITS-1:0] d);
        logic signed [DIST_BITS-1:0] neg;
        neg = -d;
        return d[DIST_BITS-1] ? neg[SIZE_BITS-1:0] : d[SIZE_BITS-1:0];
    endfunction

endpackage

### src/acr_corner.sv
// containment test of one corner against the other box and nearest-edge choice
// depends on acr_pkg
module acr_corner #(
    parameter int EXT_W = 17
) (
    input  logic signed [EXT_W-1:0] i_px,
    input  logic signed [EXT_W-1:0] i_py,
    input  logic signed [EXT_W-1:0] i_ox0,
    input  logic signed [EXT_W-1:0] i_ox1,
    input  logic signed [EXT_W-1:0] i_oy0,
    input  logic signed [EXT_W-1:0] i_oy1,
    output acr_pkg::t_push          o_push
);
    import acr_pkg::*;

    logic signed [EXT_W-1:0]     w_diff [4];
    logic signed [DIST_BITS-1:0] w_d    [4];
    logic [SIZE_BITS-1:0]        w_m    [4];

    // differences are exact in the low bits whenever the corner is inside
    assign w_diff[0] = i_ox0 - i_px;
    assign w_diff[1] = i_ox1 - i_px;
    assign w_diff[2] = i_oy0 - i_py;
    assign w_diff[3] = i_oy1 - i_py;

    always_comb begin
        logic [1:0] best;
        best = 2'd0;
        for (int i = 0; i < 4; i++) begin
            w_d[i] = w_diff[i][DIST_BITS-1:0];
            w_m[i] = dist_mag(w_d[i]);
        end
        // ties keep the earlier edge: left, right, top, bottom
        for (int i = 1; i < 4; i++) begin
            if (w_m[i] < w_m[best]) begin
                best = 2'(i);
            end
        end
        o_push.hit   = (i_px >= i_ox0) && (i_px <= i_ox1) && (i_py >= i_oy0) && (i_py <= i_oy1);
        o_push.on_x  = ~best[1];
        o_push.depth = w_d[best];
        o_push.mag   = w_m[best];
    end

endmodule

### src/aabb_collision_resolve_core.sv
// top level of the box overlap and push-out block
// depends on acr_pkg and acr_corner
//
// One box pair is taken per cycle when start is high; busy is always low, so
// a new pair may follow every cycle. Each pair gives exactly one result; the
// pair is held first in the input register and its result then in the
// result register, with the overlap test, four corner checks and saturation
// in the single combinational pass between them. The result is shown for one
// cycle, marked by o_valid; the receiver cannot stall, so it must take it
// then. Box size, trigger mode and movability are written through the
// configuration port, which is always ready; write it only while no pair is
// in flight. An index above 3 is ignored.
module aabb_collision_resolve_core #(
    parameter int COORD_BITS = acr_pkg::COORD_BITS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // pair input
    input  logic                              start,
    output logic                              busy,
    input  logic signed [COORD_BITS-1:0]      i_self_x,
    input  logic signed [COORD_BITS-1:0]      i_self_y,
    input  logic signed [COORD_BITS-1:0]      i_other_x,
    input  logic signed [COORD_BITS-1:0]      i_other_y,
    input  logic [acr_pkg::SIZE_BITS-1:0]     i_other_width,
    input  logic [acr_pkg::SIZE_BITS-1:0]     i_other_height,
    // result output
    output logic                              o_valid,
    output logic [1:0]                        o_event_kind,
    output logic                              o_moved,
    output logic signed [COORD_BITS-1:0]      o_new_x,
    output logic signed [COORD_BITS-1:0]      o_new_y,
    // configuration write
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [acr_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [acr_pkg::CFG_DATA_W-1:0]    i_cfg_data
);
    import acr_pkg::*;

    // extended width holds origin plus size without wrapping
    localparam int EXT_W = ((COORD_BITS > SIZE_BITS) ? COORD_BITS : SIZE_BITS + 1) + 1;

    // configuration registers
    logic [SIZE_BITS-1:0] r_self_width;
    logic [SIZE_BITS-1:0] r_self_height;
    logic                 r_trigger_mode;
    logic                 r_movable;

    // input stage
    logic                         r_in_valid;
    logic signed [COORD_BITS-1:0] r_self_x;
    logic signed [COORD_BITS-1:0] r_self_y;
    logic signed [COORD_BITS-1:0] r_other_x;
    logic signed [COORD_BITS-1:0] r_other_y;
    logic [SIZE_BITS-1:0]         r_other_w;
    logic [SIZE_BITS-1:0]         r_other_h;

    // result stage
    logic                         r_out_valid;
    t_event                       r_event;
    logic                         r_moved;
    logic signed [COORD_BITS-1:0] r_new_x;
    logic signed [COORD_BITS-1:0] r_new_y;

    t_event                       n_event;
    logic                         n_moved;
    logic signed [COORD_BITS-1:0] n_new_x;
    logic signed [COORD_BITS-1:0] n_new_y;

    logic                         w_accept;
    logic signed [EXT_W-1:0]      w_sx0, w_sy0, w_sx1, w_sy1;
    logic signed [EXT_W-1:0]      w_ox0, w_oy0, w_ox1, w_oy1;
    logic                         w_overlap;
    t_push                        w_push [4];
    logic                         w_found;
    logic                         w_best_x;
    logic signed [DIST_BITS-1:0]  w_best_d;
    logic signed [EXT_W-1:0]      w_sum_x, w_sum_y;
    logic signed [COORD_BITS-1:0] w_sat_x, w_sat_y;

    assign busy        = 1'b0;
    assign o_cfg_ready = 1'b1;
    assign w_accept    = start & ~busy;

    // configuration transaction
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_self_width   <= '0;
            r_self_height  <= '0;
            r_trigger_mode <= 1'b0;
            r_movable      <= 1'b0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_SELF_WIDTH:   r_self_width   <= i_cfg_data;
                CFG_SELF_HEIGHT:  r_self_height  <= i_cfg_data;
                CFG_TRIGGER_MODE: r_trigger_mode <= i_cfg_data[0];
                CFG_MOVABLE:      r_movable      <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else begin
            r_in_valid <= w_accept;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_self_x  <= i_self_x;
            r_self_y  <= i_self_y;
            r_other_x <= i_other_x;
            r_other_y <= i_other_y;
            r_other_w <= i_other_width;
            r_other_h <= i_other_height;
        end
    end

    // box extents in the widened range
    assign w_sx0 = {{(EXT_W-COORD_BITS){r_self_x[COORD_BITS-1]}}, r_self_x};
    assign w_sy0 = {{(EXT_W-COORD_BITS){r_self_y[COORD_BITS-1]}}, r_self_y};
    assign w_ox0 = {{(EXT_W-COORD_BITS){r_other_x[COORD_BITS-1]}}, r_other_x};
    assign w_oy0 = {{(EXT_W-COORD_BITS){r_other_y[COORD_BITS-1]}}, r_other_y};
    assign w_sx1 = w_sx0 + $signed({{(EXT_W-SIZE_BITS){1'b0}}, r_self_width});
    assign w_sy1 = w_sy0 + $signed({{(EXT_W-SIZE_BITS){1'b0}}, r_self_height});
    assign w_ox1 = w_ox0 + $signed({{(EXT_W-SIZE_BITS){1'b0}}, r_other_w});
    assign w_oy1 = w_oy0 + $signed({{(EXT_W-SIZE_BITS){1'b0}}, r_other_h});

    // closed intervals, touching edges count
    assign w_overlap = (w_sx0 <= w_ox1) && (w_ox0 <= w_sx1) &&
                       (w_sy0 <= w_oy1) && (w_oy0 <= w_sy1);

    // corners in order origin, +w, +w+h, +h
    acr_corner #(.EXT_W(EXT_W)) u_corner0 (
        .i_px(w_sx0), .i_py(w_sy0), .i_ox0(w_ox0), .i_ox1(w_ox1),
        .i_oy0(w_oy0), .i_oy1(w_oy1), .o_push(w_push[0])
    );
    acr_corner #(.EXT_W(EXT_W)) u_corner1 (
        .i_px(w_sx1), .i_py(w_sy0), .i_ox0(w_ox0), .i_ox1(w_ox1),
        .i_oy0(w_oy0), .i_oy1(w_oy1), .o_push(w_push[1])
    );
    acr_corner #(.EXT_W(EXT_W)) u_corner2 (
        .i_px(w_sx1), .i_py(w_sy1), .i_ox0(w_ox0), .i_ox1(w_ox1),
        .i_oy0(w_oy0), .i_oy1(w_oy1), .o_push(w_push[2])
    );
    acr_corner #(.EXT_W(EXT_W)) u_corner3 (
        .i_px(w_sx0), .i_py(w_sy1), .i_ox0(w_ox0), .i_ox1(w_ox1),
        .i_oy0(w_oy0), .i_oy1(w_oy1), .o_push(w_push[3])
    );

    // smallest push among inside corners, earlier corner wins a tie
    always_comb begin
        logic [SIZE_BITS-1:0] best_m;
        best_m   = '0;
        w_found  = 1'b0;
        w_best_x = 1'b0;
        w_best_d = '0;
        for (int i = 0; i < 4; i++) begin
            if (w_push[i].hit && (!w_found || (w_push[i].mag < best_m))) begin
                w_found  = 1'b1;
                w_best_x = w_push[i].on_x;
                w_best_d = w_push[i].depth;
                best_m   = w_push[i].mag;
            end
        end
    end

    // pushed origin and saturation to the coordinate range
    assign w_sum_x = w_sx0 + {{(EXT_W-DIST_BITS){w_best_d[DIST_BITS-1]}}, w_best_d};
    assign w_sum_y = w_sy0 + {{(EXT_W-DIST_BITS){w_best_d[DIST_BITS-1]}}, w_best_d};

    always_comb begin
        if ((&w_sum_x[EXT_W-1:COORD_BITS-1]) || !(|w_sum_x[EXT_W-1:COORD_BITS-1])) begin
            w_sat_x = w_sum_x[COORD_BITS-1:0];
        end else if (w_sum_x[EXT_W-1]) begin
            w_sat_x = {1'b1, {(COORD_BITS-1){1'b0}}};
        end else begin
            w_sat_x = {1'b0, {(COORD_BITS-1){1'b1}}};
        end
        if ((&w_sum_y[EXT_W-1:COORD_BITS-1]) || !(|w_sum_y[EXT_W-1:COORD_BITS-1])) begin
            w_sat_y = w_sum_y[COORD_BITS-1:0];
        end else if (w_sum_y[EXT_W-1]) begin
            w_sat_y = {1'b1, {(COORD_BITS-1){1'b0}}};
        end else begin
            w_sat_y = {1'b0, {(COORD_BITS-1){1'b1}}};
        end
    end

    // event and resolution
    always_comb begin
        n_event = EV_NONE;
        n_moved = 1'b0;
        n_new_x = r_self_x;
        n_new_y = r_self_y;
        if (w_overlap) begin
            if (r_trigger_mode) begin
                n_event = EV_TRIGGER;
            end else begin
                n_event = EV_SOLID;
                // nothing moves when no corner lies inside
                if (r_movable && w_found) begin
                    n_moved = 1'b1;
                    if (w_best_x) begin
                        n_new_x = w_sat_x;
                    end else begin
                        n_new_y = w_sat_y;
                    end
                end
            end
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_in_valid) begin
            r_event <= n_event;
            r_moved <= n_moved;
            r_new_x <= n_new_x;
            r_new_y <= n_new_y;
        end
    end

    assign o_valid      = r_out_valid;
    assign o_event_kind = r_event;
    assign o_moved      = r_moved;
    assign o_new_x      = r_new_x;
    assign o_new_y      = r_new_y;

    // every registered pair gives a result in the next cycle
    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_valid |=> o_valid)
        else $error("result missing after input stage");

    // a move only happens in a solid collision
    a_move_solid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_moved) |-> (o_event_kind == EV_SOLID))
        else $error("move reported outside a solid collision");

    // without a move the origin comes back unchanged
    a_no_move_same: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_moved) |-> ((o_new_x == $past(r_self_x)) && (o_new_y == $past(r_self_y))))
        else $error("origin changed without a move");

    // a push acts along one axis only
    a_single_axis: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_moved) |-> ((o_new_x == $past(r_self_x)) || (o_new_y == $past(r_self_y))))
        else $error("push changed both axes");

endmodule

### bench/acr_push_checker.sv
`timescale 1ns / 100ps
// result checker for aabb_collision_resolve_core: predicts the overlap event and
// push-out of every accepted box pair and compares it with the result strobe
// depends on acr_pkg for the event codes and register indexes
module acr_push_checker
    import acr_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    input  logic                         i_busy,
    input  logic signed [COORD_BITS-1:0] i_self_x,
    input  logic signed [COORD_BITS-1:0] i_self_y,
    input  logic signed [COORD_BITS-1:0] i_other_x,
    input  logic signed [COORD_BITS-1:0] i_other_y,
    input  logic [SIZE_BITS-1:0]         i_other_width,
    input  logic [SIZE_BITS-1:0]         i_other_height,
    input  logic                         i_valid,
    input  logic [1:0]                   i_event_kind,
    input  logic                         i_moved,
    input  logic signed [COORD_BITS-1:0] i_new_x,
    input  logic signed [COORD_BITS-1:0] i_new_y,
    input  logic                         i_cfg_valid,
    input  logic                         i_cfg_ready,
    input  logic [CFG_IDX_W-1:0]         i_cfg_index,
    input  logic [CFG_DATA_W-1:0]        i_cfg_data,
    output int                           o_mismatches,
    output int                           o_open_results,
    output int                           o_results_seen,
    output int                           o_push_outs
);

    localparam int MAX_REPORTS = 200;
    localparam longint COORD_MAX = (longint'(1) << (COORD_BITS - 1)) - 1;
    localparam longint COORD_MIN = -COORD_MAX - 1;

    typedef struct {
        t_event                      kind;
        logic                        moved;
        logic signed [COORD_BITS-1:0] new_x;
        logic signed [COORD_BITS-1:0] new_y;
    } push_result_t;

    // register copy
    logic [SIZE_BITS-1:0] self_w;
    logic [SIZE_BITS-1:0] self_h;
    logic                 trigger_only;
    logic                 can_move;

    push_result_t expected_results[$];

    function automatic longint mag_of(input longint v);
        return (v < 0) ? -v : v;
    endfunction

    function automatic logic signed [COORD_BITS-1:0] clamp_coord(input longint v);
        longint c;
        c = (v > COORD_MAX) ? COORD_MAX : (v < COORD_MIN) ? COORD_MIN : v;
        return c[COORD_BITS-1:0];
    endfunction

    // corner inside the closed other box: signed distance to its nearest edge,
    // ties in the order left, right, top, bottom
    function automatic bit corner_depth(input longint px, py, ox0, ox1, oy0, oy1,
                                        output longint depth, output bit on_x);
        longint d[4];
        int     best;
        int     k;
        depth = 0;
        on_x  = 1'b0;
        if (px < ox0 || px > ox1 || py < oy0 || py > oy1)
            return 1'b0;
        d = '{ox0 - px, ox1 - px, oy0 - py, oy1 - py};
        best = 0;
        for (k = 1; k < 4; k++)
            if (mag_of(d[k]) < mag_of(d[best]))
                best = k;
        depth = d[best];
        on_x  = (best < 2);
        return 1'b1;
    endfunction

    function automatic push_result_t resolve_pair(input longint sx, sy, ox0, oy0, ow, oh);
        push_result_t r;
        longint       ox1, oy1, sx1, sy1;
        longint       depth, best_depth;
        longint       cx[4], cy[4];
        bit           on_x, best_on_x, found;
        int           k;
        ox1 = ox0 + ow;
        oy1 = oy0 + oh;
        sx1 = sx + longint'(self_w);
        sy1 = sy + longint'(self_h);
        r.kind  = EV_NONE;
        r.moved = 1'b0;
        r.new_x = sx[COORD_BITS-1:0];
        r.new_y = sy[COORD_BITS-1:0];
        if (sx <= ox1 && ox0 <= sx1 && sy <= oy1 && oy0 <= sy1) begin
            if (trigger_only) begin
                r.kind = EV_TRIGGER;
            end else begin
                r.kind = EV_SOLID;
                if (can_move) begin
                    // corners: origin, +w, +w+h, +h; earlier corner wins ties
                    cx = '{sx, sx1, sx1, sx};
                    cy = '{sy, sy, sy1, sy1};
                    found      = 1'b0;
                    best_depth = 0;
                    best_on_x  = 1'b0;
                    for (k = 0; k < 4; k++) begin
                        if (corner_depth(cx[k], cy[k], ox0, ox1, oy0, oy1, depth, on_x) &&
                            (!found || mag_of(depth) < mag_of(best_depth))) begin
                            found      = 1'b1;
                            best_depth = depth;
                            best_on_x  = on_x;
                        end
                    end
                    if (found) begin
                        r.moved = 1'b1;
                        if (best_on_x)
                            r.new_x = clamp_coord(sx + best_depth);
                        else
                            r.new_y = clamp_coord(sy + best_depth);
                    end
                end
            end
        end
        return r;
    endfunction

    always @(posedge i_clk) begin
        push_result_t want;
        if (!i_rst_n) begin
            self_w       = '0;
            self_h       = '0;
            trigger_only = 1'b0;
            can_move     = 1'b0;
            expected_results.delete();
        end else begin
            // prediction uses the registers as they stand before this edge
            if (i_start && !i_busy)
                expected_results.push_back(resolve_pair(i_self_x, i_self_y, i_other_x,
                                                        i_other_y, i_other_width,
                                                        i_other_height));
            if (i_valid) begin
                if (expected_results.size() == 0) begin
                    o_mismatches++;
                    if (o_mismatches <= MAX_REPORTS)
                        $display("%0t: result with no pair waiting: kind %0d moved %0d x %0d y %0d",
                                 $time, i_event_kind, i_moved, i_new_x, i_new_y);
                end else begin
                    want = expected_results.pop_front();
                    o_results_seen++;
                    if (want.moved)
                        o_push_outs++;
                    if (i_event_kind !== want.kind || i_moved !== want.moved ||
                        i_new_x !== want.new_x || i_new_y !== want.new_y) begin
                        o_mismatches++;
                        if (o_mismatches <= MAX_REPORTS)
                            $display("%0t: mismatch (expected/actual) kind %0d/%0d moved %0d/%0d x %0d/%0d y %0d/%0d",
                                     $time, want.kind, i_event_kind, want.moved, i_moved,
                                     want.new_x, i_new_x, want.new_y, i_new_y);
                    end
                end
            end
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    CFG_SELF_WIDTH:   self_w       = i_cfg_data;
                    CFG_SELF_HEIGHT:  self_h       = i_cfg_data;
                    CFG_TRIGGER_MODE: trigger_only = i_cfg_data[0];
                    CFG_MOVABLE:      can_move     = i_cfg_data[0];
                    default: ;
                endcase
            end
        end
        o_open_results = expected_results.size();
    end

endmodule

### bench/testbench.sv
`timescale 1ns / 100ps
// stimulus and verdict for aabb_collision_resolve_core
// depends on acr_pkg, the block itself and acr_push_checker
module testbench;
    import acr_pkg::*;

    localparam int COORD_BITS      = COORD_BITS_DEF;
    // a result passes the input register, then the result register
    localparam int RESULT_LATENCY  = 2;
    localparam int WATCHDOG_LIMIT  = 2000;
    localparam int RAND_PHASES     = 6;
    localparam int PAIRS_PER_PHASE = 140;
    localparam int SIZE_MAX        = (1 << SIZE_BITS) - 1;
    // boxes in the near-miss generator mostly stay small
    localparam int SMALL_SIZE      = 300;
    localparam longint COORD_MAX   = (longint'(1) << (COORD_BITS - 1)) - 1;
    localparam longint COORD_MIN   = -COORD_MAX - 1;
    // indexes past the last register, which the block must ignore
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_FIRST = CFG_MOVABLE + 1'b1;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LAST  = '1;

    logic                         i_clk;
    logic                         i_rst_n;
    logic                         start;
    logic                         busy;
    logic signed [COORD_BITS-1:0] i_self_x;
    logic signed [COORD_BITS-1:0] i_self_y;
    logic signed [COORD_BITS-1:0] i_other_x;
    logic signed [COORD_BITS-1:0] i_other_y;
    logic [SIZE_BITS-1:0]         i_other_width;
    logic [SIZE_BITS-1:0]         i_other_height;
    logic                         o_valid;
    logic [1:0]                   o_event_kind;
    logic                         o_moved;
    logic signed [COORD_BITS-1:0] o_new_x;
    logic signed [COORD_BITS-1:0] o_new_y;
    logic                         i_cfg_valid;
    logic                         o_cfg_ready;
    logic [CFG_IDX_W-1:0]         i_cfg_index;
    logic [CFG_DATA_W-1:0]        i_cfg_data;

    // from the checker
    int mismatches;
    int open_results;
    int results_seen;
    int push_outs;

    // stimulus bookkeeping
    int pairs_sent;
    int settings_used;
    int idle_pct;
    int cur_w;
    int cur_h;
    int quiet_cycles;
    // sender idle percentage per random phase: none, heavy, moderate
    int idle_plan[3] = '{0, 88, 34};

    aabb_collision_resolve_core #(
        .COORD_BITS(COORD_BITS)
    ) uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .start         (start),
        .busy          (busy),
        .i_self_x      (i_self_x),
        .i_self_y      (i_self_y),
        .i_other_x     (i_other_x),
        .i_other_y     (i_other_y),
        .i_other_width (i_other_width),
        .i_other_height(i_other_height),
        .o_valid       (o_valid),
        .o_event_kind  (o_event_kind),
        .o_moved       (o_moved),
        .o_new_x       (o_new_x),
        .o_new_y       (o_new_y),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    acr_push_checker #(
        .COORD_BITS(COORD_BITS)
    ) u_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_start       (start),
        .i_busy        (busy),
        .i_self_x      (i_self_x),
        .i_self_y      (i_self_y),
        .i_other_x     (i_other_x),
        .i_other_y     (i_other_y),
        .i_other_width (i_other_width),
        .i_other_height(i_other_height),
        .i_valid       (o_valid),
        .i_event_kind  (o_event_kind),
        .i_moved       (o_moved),
        .i_new_x       (o_new_x),
        .i_new_y       (o_new_y),
        .i_cfg_valid   (i_cfg_valid),
        .i_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .o_mismatches  (mismatches),
        .o_open_results(open_results),
        .o_results_seen(results_seen),
        .o_push_outs   (push_outs)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // watchdog: any pair, result or register transaction counts as progress
    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_valid || (i_cfg_valid && o_cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: no transaction for %0d cycles", $time, WATCHDOG_LIMIT);
            $display("testbench failed");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // keep generated coordinates inside the signed port range
    function automatic logic signed [COORD_BITS-1:0] fit_coord(input longint v);
        longint c;
        c = (v > COORD_MAX) ? COORD_MAX : (v < COORD_MIN) ? COORD_MIN : v;
        return c[COORD_BITS-1:0];
    endfunction

    // all tasks below are entered and left at a falling edge

    // one pair transaction; start stays high on return so back-to-back pairs
    // go out on consecutive cycles
    task automatic send_pair(input longint sx, sy, ox, oy, input int ow, oh);
        while ($urandom_range(99) < idle_pct) begin
            start = 1'b0;
            @(negedge i_clk);
        end
        i_self_x       = fit_coord(sx);
        i_self_y       = fit_coord(sy);
        i_other_x      = fit_coord(ox);
        i_other_y      = fit_coord(oy);
        i_other_width  = ow[SIZE_BITS-1:0];
        i_other_height = oh[SIZE_BITS-1:0];
        start          = 1'b1;
        @(posedge i_clk);
        while (busy)
            @(posedge i_clk);
        @(negedge i_clk);
        pairs_sent++;
    endtask

    // stop sending and let every outstanding result come back
    task automatic wait_drained();
        start = 1'b0;
        while (open_results != 0)
            @(negedge i_clk);
        repeat (RESULT_LATENCY + 1) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        i_cfg_index = idx;
        i_cfg_data  = data;
        i_cfg_valid = 1'b1;
        @(posedge i_clk);
        while (!o_cfg_ready)
            @(posedge i_clk);
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
        @(negedge i_clk);
    endtask

    // full register set, written only with the pipe empty; the one-bit
    // registers get random upper data bits that must be dropped
    task automatic apply_setting(input logic [SIZE_BITS-1:0] w, h, input logic trig, mov);
        logic [CFG_DATA_W-1:0] noise;
        wait_drained();
        noise = CFG_DATA_W'($urandom);
        write_reg(CFG_SELF_WIDTH, w);
        write_reg(CFG_SELF_HEIGHT, h);
        write_reg(CFG_TRIGGER_MODE, {noise[CFG_DATA_W-1:1], trig});
        noise = CFG_DATA_W'($urandom);
        write_reg(CFG_MOVABLE, {noise[CFG_DATA_W-1:1], mov});
        cur_w = w;
        cur_h = h;
        settings_used++;
    endtask

    initial begin
        int     phase;
        int     k;
        int     mode;
        int     ow;
        int     oh;
        longint sx;
        longint sy;
        longint ox;
        longint oy;

        i_rst_n        = 1'b0;
        start          = 1'b0;
        i_self_x       = '0;
        i_self_y       = '0;
        i_other_x      = '0;
        i_other_y      = '0;
        i_other_width  = '0;
        i_other_height = '0;
        i_cfg_valid    = 1'b0;
        i_cfg_index    = CFG_SELF_WIDTH;
        i_cfg_data     = '0;
        pairs_sent     = 0;
        settings_used  = 0;
        idle_pct       = 0;
        cur_w          = 0;
        cur_h          = 0;

        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        // ---- directed part ----
        // registers at reset: point box, solid, not movable
        send_pair(0, 0, 0, 0, 0, 0);
        send_pair(COORD_MAX, COORD_MIN, COORD_MIN, COORD_MAX, SIZE_MAX, SIZE_MAX);
        send_pair(COORD_MIN, COORD_MAX, COORD_MAX, COORD_MIN, SIZE_MAX, SIZE_MAX);

        // trigger box: overlap only reported; edge contact counts as overlap
        apply_setting(100, 50, 1'b1, 1'b1);
        send_pair(0, 0, 50, 20, 100, 100);
        send_pair(0, 0, 100, 50, 10, 10);
        send_pair(0, 0, 101, 0, 10, 10);

        // solid movable box, 100 x 50
        apply_setting(100, 50, 1'b0, 1'b1);
        send_pair(0, 0, 90, -100, 200, 300);        // push left, two corners tie
        send_pair(0, 0, -200, -100, 210, 300);      // push right
        send_pair(0, 0, -100, 40, 300, 100);        // push up
        send_pair(0, 0, -100, -100, 300, 110);      // push down
        send_pair(0, 0, -10, -100, 20, 300);        // left and right equal, left wins
        send_pair(0, 0, -10, -10, 500, 500);        // left and top equal, left wins
        send_pair(0, 0, 10, 10, 20, 20);            // other box inside, no corner inside
        send_pair(0, 0, 20, -100, 10, 300);         // crossing boxes, no corner inside
        send_pair(0, 0, 100, 0, 50, 50);            // corner on the edge, zero push
        // pushes that run past the coordinate range and saturate
        send_pair(COORD_MAX - 7, 0, COORD_MAX - 767, -1000, 800, 2000);
        send_pair(COORD_MIN, 0, COORD_MIN + 68, -1000, 2000, 2000);
        send_pair(0, COORD_MAX - 7, -1000, COORD_MAX - 767, 2000, 800);
        send_pair(0, COORD_MIN, -1000, COORD_MIN + 28, 2000, 2000);

        // largest box, not movable; writes past the last index change nothing
        apply_setting(SIZE_MAX, SIZE_MAX, 1'b0, 1'b0);
        write_reg(CFG_SPARE_FIRST, CFG_DATA_W'($urandom));
        write_reg(CFG_SPARE_LAST, CFG_DATA_W'($urandom));
        send_pair(0, 0, 1000, 1000, 10, 10);

        apply_setting(SIZE_MAX, SIZE_MAX, 1'b0, 1'b1);
        send_pair(COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX, SIZE_MAX, SIZE_MAX);
        send_pair(COORD_MIN, COORD_MIN, COORD_MIN + SIZE_MAX, COORD_MIN + SIZE_MAX, 0, 0);

        // ---- random part ----
        for (phase = 0; phase < RAND_PHASES; phase++) begin
            case (phase)
                0:       apply_setting(0, 0, 1'b0, 1'b1);
                1:       apply_setting(SIZE_MAX, SIZE_MAX, 1'b0, 1'b1);
                3:       apply_setting(SIZE_BITS'($urandom_range(SIZE_MAX)),
                                       SIZE_BITS'($urandom_range(SIZE_MAX)),
                                       1'b1, 1'($urandom_range(1)));
                4:       apply_setting(SIZE_BITS'($urandom_range(SMALL_SIZE)),
                                       SIZE_BITS'($urandom_range(SMALL_SIZE)),
                                       1'b0, 1'b0);
                default: apply_setting(SIZE_BITS'($urandom_range(SMALL_SIZE, 1)),
                                       SIZE_BITS'($urandom_range(SMALL_SIZE, 1)), 1'b0, 1'b1);
            endcase
            idle_pct = idle_plan[phase % 3];

            for (k = 0; k < PAIRS_PER_PHASE; k++) begin
                ow   = ($urandom_range(4) == 0) ? $urandom_range(SIZE_MAX)
                                                : $urandom_range(SMALL_SIZE);
                oh   = ($urandom_range(4) == 0) ? $urandom_range(SIZE_MAX)
                                                : $urandom_range(SMALL_SIZE);
                mode = $urandom_range(99);
                if (mode < 75) begin
                    // other box placed around this one so most pairs touch
                    if (mode < 60) begin
                        sx = longint'($urandom_range(COORD_MAX - COORD_MIN)) + COORD_MIN;
                        sy = longint'($urandom_range(COORD_MAX - COORD_MIN)) + COORD_MIN;
                    end else begin
                        // hugging the range limits to provoke saturation
                        sx = $urandom_range(1) ? COORD_MAX - $urandom_range(SMALL_SIZE)
                                               : COORD_MIN + $urandom_range(SMALL_SIZE);
                        sy = $urandom_range(1) ? COORD_MAX - $urandom_range(SMALL_SIZE)
                                               : COORD_MIN + $urandom_range(SMALL_SIZE);
                    end
                    ox = sx - ow - 2 + longint'($urandom_range(ow + cur_w + 4));
                    oy = sy - oh - 2 + longint'($urandom_range(oh + cur_h + 4));
                end else begin
                    // unrelated boxes, every field fully random
                    sx = longint'($urandom_range(COORD_MAX - COORD_MIN)) + COORD_MIN;
                    sy = longint'($urandom_range(COORD_MAX - COORD_MIN)) + COORD_MIN;
                    ox = longint'($urandom_range(COORD_MAX - COORD_MIN)) + COORD_MIN;
                    oy = longint'($urandom_range(COORD_MAX - COORD_MIN)) + COORD_MIN;
                    ow = $urandom_range(SIZE_MAX);
                    oh = $urandom_range(SIZE_MAX);
                end
                send_pair(sx, sy, ox, oy, ow, oh);
                // now and then hold off until the pipe is empty
                if ($urandom_range(150) == 0)
                    wait_drained();
            end
        end

        wait_drained();
        repeat (RESULT_LATENCY + 4) @(negedge i_clk);

        $display("covered %0d box pairs under %0d register settings, sender idle 0/34/88 percent",
                 pairs_sent, settings_used);
        $display("%0d results compared, %0d of them with a push-out", results_seen, push_outs);
        if (mismatches == 0 && open_results == 0) begin
            $display("testbench passed");
        end else begin
            $display("testbench failed");
        end
        $finish;
    end

endmodule
